[sv/assert_macros.svh]
// Assertion macros used by the RTL of the segment formatter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sts_pkg.sv]
// Package with segment codes, limits and the digit decoder of the segment formatter.
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

  localparam logic signed [15:0] HI_LIMIT    = 16'sd19995;
  localparam logic signed [15:0] LO_LIMIT    = -16'sd995;
  localparam logic signed [15:0] FRAC_HI_LIM = 16'sd1995;
  localparam logic signed [15:0] FRAC_LO_LIM = -16'sd95;

  localparam logic [7:0] SEG_H     = 8'h67;
  localparam logic [7:0] SEG_I     = 8'h40;
  localparam logic [7:0] SEG_L     = 8'hE0;
  localparam logic [7:0] SEG_O     = 8'hC6;
  localparam logic [7:0] SEG_ZERO  = 8'hF5;
  localparam logic [7:0] SEG_MINUS = 8'h02;
  localparam logic [7:0] SEG_ONE   = 8'h08;
  localparam logic [7:0] SEG_POINT = 8'h08;
  localparam logic [7:0] SEG_UNDER = 8'h08;

  // Reciprocals for division by 10, 100 and 1000 of values below 32768.
  localparam logic [16:0] RECIP_10   = 17'd52429;
  localparam logic [16:0] RECIP_100  = 17'd5243;
  localparam logic [16:0] RECIP_1000 = 17'd67109;

  function automatic logic [7:0] digit_segs(input logic [3:0] digit);
    logic [7:0] segs;
    case (digit)
      4'd0:    segs = 8'hF5;
      4'd1:    segs = 8'h05;
      4'd2:    segs = 8'hD3;
      4'd3:    segs = 8'h97;
      4'd4:    segs = 8'h27;
      4'd5:    segs = 8'hB6;
      4'd6:    segs = 8'hF6;
      4'd7:    segs = 8'h15;
      4'd8:    segs = 8'hF7;
      4'd9:    segs = 8'hB7;
      default: segs = 8'h00;
    endcase
    return segs;
  endfunction

endpackage

`default_nettype wire

[sv/signed_tenths_to_segments_unit.sv]
// Top level of the signed tenths to LCD segment formatter.
// Each input transfer carries a signed reading in tenths and a symbol byte; each output
// transfer carries three segment bytes and two unit marks. The unit takes one transfer per
// clock while the output is not stalled, and holds each reading in the input register and
// its result in the result register, with the digit split done by constant reciprocal
// multiplies in between. Backpressure on the output stalls both registers in turn.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module signed_tenths_to_segments_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // value_tenths [15:0], unit_symbol [23:16]
  input  wire logic [23:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // seg_digit_high [7:0], seg_digit_mid [15:8], seg_digit_low [23:16],
  // mark_upper [24], mark_lower [25], zero [31:26]
  output logic [31:0]      m_axis_tdata_o
);
  import sts_pkg::*;

  logic               in_vld_q;
  logic signed [15:0] value_q;
  logic [7:0]         symbol_q;
  logic               out_vld_q;
  logic [25:0]        result_q;
  logic [25:0]        result_d;
  logic               out_ready;
  logic               in_ready;
  logic [7:0]         out_hi;
  logic [7:0]         out_mid;

  logic        too_hi, too_lo, neg, rnd;
  logic [15:0] abs_full;
  logic [14:0] mag_x;
  logic [31:0] prod_10, prod_100, prod_1000;
  logic [12:0] q1, q2;
  logic [5:0]  q3;
  logic [15:0] e0_w;
  logic [12:0] e1_w, e2_w;
  logic [3:0]  e0, e1, e2, e3;
  logic [3:0]  units, tens, hund;
  logic [14:0] mag;
  logic [7:0]  seg_hi, seg_mid, seg_lo;

  assign out_ready       = !out_vld_q || m_axis_tready_i;
  assign in_ready        = !in_vld_q || out_ready;
  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'd0, result_q};
  assign out_hi          = result_q[7:0];
  assign out_mid         = result_q[15:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (out_ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      value_q  <= $signed(s_axis_tdata_i[15:0]);
      symbol_q <= s_axis_tdata_i[23:16];
    end
    if (out_ready && in_vld_q) begin
      result_q <= result_d;
    end
  end

  always_comb begin
    too_hi   = value_q > HI_LIMIT;
    too_lo   = value_q < LO_LIMIT;
    neg      = value_q[15];
    rnd      = (value_q > FRAC_HI_LIM) || (value_q < FRAC_LO_LIM);
    abs_full = neg ? (16'd0 - value_q) : value_q;
    mag_x    = abs_full[14:0] + (rnd ? 15'd5 : 15'd0);

    prod_10   = {17'd0, mag_x} * {15'd0, RECIP_10};
    prod_100  = {17'd0, mag_x} * {15'd0, RECIP_100};
    prod_1000 = {17'd0, mag_x} * {15'd0, RECIP_1000};
    q1 = prod_10[31:19];
    q2 = prod_100[31:19];
    q3 = prod_1000[31:26];

    e0_w = {1'b0, mag_x} - ({q1, 3'd0} + {2'b0, q1, 1'b0});
    e1_w = q1 - ({q2[9:0], 3'd0} + {q2[11:0], 1'b0});
    e2_w = q2 - ({4'd0, q3, 3'd0} + {6'd0, q3, 1'b0});
    e0   = e0_w[3:0];
    e1   = e1_w[3:0];
    e2   = e2_w[3:0];
    if (q3 >= 6'd20) begin
      e3 = 4'(q3 - 6'd20);
    end else if (q3 >= 6'd10) begin
      e3 = 4'(q3 - 6'd10);
    end else begin
      e3 = q3[3:0];
    end

    units = rnd ? e1 : e0;
    tens  = rnd ? e2 : e1;
    hund  = rnd ? e3 : e2;
    mag   = rnd ? {2'd0, q1} : mag_x;

    seg_lo = symbol_q[7] ? SEG_UNDER : 8'h00;
    if (too_hi) begin
      seg_hi  = SEG_H;
      seg_mid = SEG_I;
    end else if (too_lo) begin
      seg_hi  = SEG_L;
      seg_mid = SEG_O;
    end else begin
      seg_hi  = (neg ? SEG_MINUS : 8'h00)
              | ((mag > 15'd999) ? SEG_ONE : 8'h00)
              | ((mag > 15'd99) ? digit_segs(hund) : 8'h00);
      seg_mid = (rnd ? 8'h00 : SEG_POINT)
              | ((mag > 15'd9) ? digit_segs(tens) : SEG_ZERO);
      seg_lo  = seg_lo | digit_segs(units);
    end

    result_d = {symbol_q[6], symbol_q[5], seg_lo, seg_mid, seg_hi};
  end

  `ASSERT_NEXT(a_stage_moves, in_vld_q && out_ready, out_vld_q, "Input stage item was lost.")
  `ASSERT_CLK(a_hi_pair, !out_vld_q || out_hi != SEG_H || out_mid == SEG_I, "Hi without i.")
  `ASSERT_CLK(a_lo_pair, !out_vld_q || out_hi != SEG_L || out_mid == SEG_O, "Lo without o.")

endmodule

`default_nettype wire

[tb/sv/tb_signed_tenths_to_segments_unit.sv]
// Self-checking testbench for the signed tenths to LCD segment formatter.
`timescale 1ns / 1ps

module tb_signed_tenths_to_segments_unit;
  import sts_pkg::*;

  localparam int CLK_HALF   = 10;
  localparam int IDLE_LIMIT = 1000;
  localparam int NUM_RANDOM = 1700;
  localparam int TAIL_WAIT  = 8;

  localparam logic [7:0] DIGIT_SEGS [10] = '{
    8'hF5, 8'h05, 8'hD3, 8'h97, 8'h27, 8'hB6, 8'hF6, 8'h15, 8'hF7, 8'hB7
  };

  typedef struct {
    logic [15:0] value;
    logic [7:0]  symbol;
    bit          drain;
  } reading_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic [23:0] s_axis_tdata_i  = '0;
  logic        m_axis_tready_i = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;

  reading_t    pending_readings[$];
  logic [31:0] expected_segments[$];
  int          error_count = 0;
  int          burst_left  = 1;
  int          gap_left    = 0;
  int          stall_mode  = 0;
  int          mode_left   = 0;
  int          stall_phase = 0;
  int          idle_cycles = 0;

  signed_tenths_to_segments_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  function automatic logic [31:0] predict_segments(input logic [15:0] value,
                                                   input logic [7:0]  symbol);
    int          reading;
    int          mag;
    logic [7:0]  hi;
    logic [7:0]  mid;
    logic [7:0]  lo;
    reading = int'($signed(value));
    hi      = 8'h00;
    mid     = 8'h00;
    lo      = symbol[7] ? SEG_UNDER : 8'h00;
    if (reading > int'(HI_LIMIT)) begin
      hi  = SEG_H;
      mid = SEG_I;
    end else if (reading < int'(LO_LIMIT)) begin
      hi  = SEG_L;
      mid = SEG_O;
    end else begin
      if (reading < 0) begin
        hi  = SEG_MINUS;
        mag = -reading;
      end else begin
        mag = reading;
      end
      if (reading > int'(FRAC_HI_LIM) || reading < int'(FRAC_LO_LIM)) begin
        mag = (mag + 5) / 10;
      end else begin
        mid = SEG_POINT;
      end
      if (mag > 999) hi |= SEG_ONE;
      if (mag > 99) hi |= DIGIT_SEGS[(mag / 100) % 10];
      if (mag > 9) begin
        mid |= DIGIT_SEGS[(mag / 10) % 10];
      end else begin
        mid |= SEG_ZERO;
      end
      lo |= DIGIT_SEGS[mag % 10];
    end
    return {6'b0, symbol[6], symbol[5], lo, mid, hi};
  endfunction

  task automatic add_reading(input int value, input logic [7:0] symbol, input bit drain);
    reading_t item;
    item.value  = 16'(value);
    item.symbol = symbol;
    item.drain  = drain;
    pending_readings.push_back(item);
  endtask

  task automatic report_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      error_count++;
    end
  endtask

  function automatic int pick_reading();
    int thresholds [10] = '{19995, -995, 1995, -95, 19991, 999, 99, 9, 0, -9};
    case ($urandom_range(0, 9))
      0, 1: return int'($signed(16'($urandom())));
      2, 3, 4, 5, 6: return int'($urandom_range(0, 20990)) - 995;
      7: return thresholds[$urandom_range(0, 9)] + int'($urandom_range(0, 6)) - 3;
      8: return int'($urandom_range(0, 300)) - 150;
      default: return int'($urandom_range(0, 60)) - 30 + 10 * int'($urandom_range(190, 210));
    endcase
  endfunction

  // Sender: bursts of transfers separated by random gaps; a drain-marked reading
  // is held back until every outstanding result has been collected.
  always @(posedge clk_i or negedge rst_ni) begin : reading_driver
    logic     next_valid;
    logic     slot_busy;
    reading_t item;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_segments.push_back(
          predict_segments(s_axis_tdata_i[15:0], s_axis_tdata_i[23:16]));
      end
      slot_busy  = s_axis_tvalid_i && !s_axis_tready_o;
      next_valid = slot_busy;
      if (!slot_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_readings.size() != 0 &&
                     !(pending_readings[0].drain && expected_segments.size() != 0)) begin
          item = pending_readings.pop_front();
          s_axis_tdata_i <= {item.symbol, item.value};
          next_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 7) == 0) begin
              burst_left = $urandom_range(100, 300);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 40);
              gap_left   = $urandom_range(0, 8);
            end
          end
        end
      end
      s_axis_tvalid_i <= next_valid;
    end
  end

  // Receiver: switches between always ready, random stalls and a fixed pattern.
  always @(posedge clk_i or negedge rst_ni) begin : result_sink
    logic ready;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      stall_phase = (stall_phase + 1) % 5;
      case (stall_mode)
        0:       ready = 1'b1;
        1:       ready = ($urandom_range(0, 9) < 7);
        2:       ready = (stall_phase < 3);
        default: ready = ($urandom_range(0, 9) < 3);
      endcase
      m_axis_tready_i <= ready;
    end
  end

  always @(posedge clk_i) begin : result_monitor
    logic [31:0] want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_segments.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h",
                 $time, m_axis_tdata_o);
        error_count++;
      end else begin
        want = expected_segments.pop_front();
        report_field("seg_digit_high", want[7:0], m_axis_tdata_o[7:0]);
        report_field("seg_digit_mid", want[15:8], m_axis_tdata_o[15:8]);
        report_field("seg_digit_low", want[23:16], m_axis_tdata_o[23:16]);
        report_field("mark_upper", {7'b0, want[24]}, {7'b0, m_axis_tdata_o[24]});
        report_field("mark_lower", {7'b0, want[25]}, {7'b0, m_axis_tdata_o[25]});
        report_field("padding", {2'b0, want[31:26]}, {2'b0, m_axis_tdata_o[31:26]});
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // Range limits, display-mode boundaries, rounding at the top and small magnitudes.
    add_reading(0, 8'h00, 1'b0);
    add_reading(32767, 8'hFF, 1'b0);
    add_reading(-32768, 8'h00, 1'b0);
    add_reading(19996, 8'h80, 1'b0);
    add_reading(19995, 8'h20, 1'b0);
    add_reading(19991, 8'h40, 1'b0);
    add_reading(19990, 8'hE0, 1'b0);
    add_reading(-995, 8'h1F, 1'b0);
    add_reading(-996, 8'h80, 1'b0);
    add_reading(1995, 8'h60, 1'b0);
    add_reading(1996, 8'hA0, 1'b0);
    add_reading(-95, 8'hC0, 1'b0);
    add_reading(-96, 8'h01, 1'b0);
    add_reading(-99, 8'h7F, 1'b0);
    add_reading(9, 8'h80, 1'b0);
    add_reading(10, 8'h20, 1'b0);
    add_reading(99, 8'h40, 1'b0);
    add_reading(100, 8'hFF, 1'b0);
    add_reading(999, 8'h00, 1'b0);
    add_reading(1000, 8'h55, 1'b0);
    add_reading(-1, 8'hAA, 1'b0);
    add_reading(-9, 8'h80, 1'b0);
    add_reading(2005, 8'h20, 1'b0);
    add_reading(9995, 8'h40, 1'b0);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      add_reading(pick_reading(), 8'($urandom()), (i == 0) || (i % 600 == 599));
    end

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_readings.size() != 0 || s_axis_tvalid_i || expected_segments.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
